// ===== rtl/pid_pkg.sv =====
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types, constants and helpers for the leaky-integral PID controller.
// ----------------------------------------------------------------------------
package pid_pkg;

    localparam int PID_HISTORY_DEPTH = 8;
    localparam int QUEUE_DEPTH       = 2;
    localparam int CFG_ADDR_W        = 5;

    // magnitude of diff * rate * 256 fits in 40 bits
    localparam int DIV_W = 40;

    localparam logic [2:0] REG_GAIN_P       = 3'd0;
    localparam logic [2:0] REG_GAIN_I       = 3'd1;
    localparam logic [2:0] REG_GAIN_D       = 3'd2;
    localparam logic [2:0] REG_LEAK_ALPHA   = 3'd3;
    localparam logic [2:0] REG_TICK_PERIOD  = 3'd4;
    localparam logic [2:0] REG_TICK_RATE_HZ = 3'd5;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic        [15:0] leak_alpha;
        logic        [15:0] tick_period;
        logic        [15:0] tick_rate_hz;
    } pid_cfg_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic signed [16:0] diff;
        logic               dvalid;
    } pid_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// ===== rtl/pid_regs.sv =====
// ----------------------------------------------------------------------------
// pid_regs
// APB register file holding gains, leak factor, tick period and tick rate.
// ----------------------------------------------------------------------------
module pid_regs
    import pid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output pid_cfg_t              cfg
);

    pid_cfg_t   cfg_reg;
    pid_cfg_t   cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GAIN_P:       cfg_next.gain_p       = pwdata[15:0];
                REG_GAIN_I:       cfg_next.gain_i       = pwdata[15:0];
                REG_GAIN_D:       cfg_next.gain_d       = pwdata[15:0];
                REG_LEAK_ALPHA:   cfg_next.leak_alpha   = pwdata[15:0];
                REG_TICK_PERIOD:  cfg_next.tick_period  = pwdata[15:0];
                REG_TICK_RATE_HZ: cfg_next.tick_rate_hz = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GAIN_P:       prdata = {16'd0, cfg_reg.gain_p};
            REG_GAIN_I:       prdata = {16'd0, cfg_reg.gain_i};
            REG_GAIN_D:       prdata = {16'd0, cfg_reg.gain_d};
            REG_LEAK_ALPHA:   prdata = {16'd0, cfg_reg.leak_alpha};
            REG_TICK_PERIOD:  prdata = {16'd0, cfg_reg.tick_period};
            REG_TICK_RATE_HZ: prdata = {16'd0, cfg_reg.tick_rate_hz};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p       <= '0;
            cfg_reg.gain_i       <= '0;
            cfg_reg.gain_d       <= '0;
            cfg_reg.leak_alpha   <= '0;
            cfg_reg.tick_period  <= 16'hFFFF;
            cfg_reg.tick_rate_hz <= 16'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/pid_front.sv =====
// ----------------------------------------------------------------------------
// pid_front
// Accepts samples, keeps the history window and fill count, forms the
// window difference and classifies each sample as derivative-valid or not.
// ----------------------------------------------------------------------------
module pid_front
    import pid_pkg::*;
#(
    parameter int HISTORY_DEPTH = PID_HISTORY_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        q_full,
    output logic        push,
    output pid_item_t   item
);

    localparam int HW = HISTORY_DEPTH - 1;
    localparam int FW = $clog2(HISTORY_DEPTH);

    logic signed [15:0] hist_reg [HW];
    logic [FW-1:0]      fill_reg;
    logic [FW-1:0]      fill_next;
    logic               full_win;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;
    assign full_win = (fill_reg == FW'(HISTORY_DEPTH - 1));

    assign item.sample = s_tdata;
    assign item.diff   = $signed({s_tdata[15], s_tdata})
                       - $signed({hist_reg[HW-1][15], hist_reg[HW-1]});
    assign item.dvalid = full_win;

    assign fill_next = (push && !full_win) ? fill_reg + 1'b1 : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            hist_reg[0] <= s_tdata;
            for (int k = 1; k < HW; k++)
                hist_reg[k] <= hist_reg[k-1];
        end
    end

    a_fill_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full_win) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count did not advance on a filling sample");

endmodule

// ===== rtl/pid_queue.sv =====
// ----------------------------------------------------------------------------
// pid_queue
// Short request queue between the front end and the compute back end.
// ----------------------------------------------------------------------------
module pid_queue
    import pid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pid_item_t push_item,
    input  logic      pop,
    output pid_item_t pop_item,
    output logic      full,
    output logic      empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    pid_item_t     mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] wr_next;
    logic [PW-1:0] rd_reg;
    logic [PW-1:0] rd_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    assign full     = (cnt_reg == CW'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem_reg[rd_reg];

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (push)
            wr_next = (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

// ===== rtl/pid_back.sv =====
// ----------------------------------------------------------------------------
// pid_back
// Sequencer that updates the leaky integral, divides the windowed difference
// by the window depth with a reciprocal multiply, and forms the saturated
// drive value.
// ----------------------------------------------------------------------------
module pid_back
    import pid_pkg::*;
#(
    parameter int HISTORY_DEPTH = PID_HISTORY_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  pid_cfg_t    cfg,
    input  logic        q_empty,
    output logic        pop,
    input  pid_item_t   q_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] drive_value,
    output logic        derivative_valid
);

    // floor(256 * y / depth) = (y * RECIP) >> RSH for any 32-bit magnitude y
    localparam int          DL       = $clog2(HISTORY_DEPTH);
    localparam int          RSH      = 32 + DL;
    localparam logic [40:0] RECIP    = 41'(((74'd1 << (40 + DL)) + 74'(HISTORY_DEPTH - 1))
                                           / 74'(HISTORY_DEPTH));
    localparam logic [20:0] RECIP_LO = RECIP[20:0];
    localparam logic [19:0] RECIP_HI = RECIP[40:21];

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_INTEG, S_DIV, S_QUO, S_DSAT, S_PROD, S_SUM1, S_SUM2
    } state_t;

    state_t             state_reg;
    pid_item_t          cur_reg;
    logic signed [31:0] integ_reg;
    logic signed [49:0] prod_a_reg;
    logic signed [33:0] y_reg;
    logic signed [50:0] prod_b_reg;
    logic [31:0]        ymag_reg;
    logic [52:0]        plo_reg;
    logic [51:0]        phi_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic               neg_reg;
    logic signed [31:0] d_reg;
    logic signed [31:0] pp_reg;
    logic signed [47:0] pi_reg;
    logic signed [47:0] pd_reg;
    logic signed [49:0] acc_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;
    logic               out_flag_reg;

    logic [16:0]        leak;
    logic signed [49:0] mul_a;
    logic signed [33:0] mul_y;
    logic signed [49:0] r1_full;
    logic signed [50:0] mul_b;
    logic signed [50:0] r2_full;
    logic signed [63:0] integ_wide;
    logic signed [33:0] y_abs;
    logic [72:0]        recip_prod;
    logic [DIV_W-1:0]   quo_next;
    logic signed [63:0] d_wide;
    logic signed [49:0] sum1;
    logic signed [63:0] tot;
    logic signed [63:0] rnd;
    logic               out_free;

    assign pop              = (state_reg == S_IDLE) && !q_empty;
    assign m_tvalid         = out_valid_reg;
    assign drive_value      = out_data_reg;
    assign derivative_valid = out_flag_reg;
    assign out_free         = !out_valid_reg || m_tready;

    assign leak       = 17'h10000 - {1'b0, cfg.leak_alpha};
    assign mul_a      = integ_reg * $signed({1'b0, leak});
    assign mul_y      = $signed(cur_reg.diff) * $signed({1'b0, cfg.tick_rate_hz});
    assign r1_full    = (prod_a_reg + 50'sd32768) >>> 16;
    assign mul_b      = $signed(r1_full[33:0]) * $signed({1'b0, cfg.tick_period});
    assign r2_full    = (prod_b_reg + 51'sd32768) >>> 16;
    assign integ_wide = $signed(r2_full[34:0]) + ($signed(cur_reg.sample) <<< 8);
    assign y_abs      = y_reg[33] ? -y_reg : y_reg;
    assign recip_prod = {phi_reg, 21'd0} + 73'(plo_reg);
    assign quo_next   = DIV_W'(recip_prod >> RSH);
    assign d_wide     = neg_reg ? -$signed({24'd0, quo_reg}) : $signed({24'd0, quo_reg});
    assign sum1       = ($signed(pp_reg) <<< 8) + pi_reg;
    assign tot        = acc_reg + pd_reg;
    assign rnd        = (tot + 64'sd128) >>> 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_flag_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != S_SUM2)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                        state_reg <= S_MUL1;
                end
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_INTEG;
                S_INTEG:
                begin
                    integ_reg <= sat32(integ_wide);
                    state_reg <= S_DIV;
                end
                S_DIV:   state_reg <= S_QUO;
                S_QUO:   state_reg <= S_DSAT;
                S_DSAT:  state_reg <= S_PROD;
                S_PROD:  state_reg <= S_SUM1;
                S_SUM1:  state_reg <= S_SUM2;
                S_SUM2:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= sat32(rnd);
                        out_flag_reg  <= cur_reg.dvalid;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                    cur_reg <= q_item;
            end
            S_MUL1:
            begin
                prod_a_reg <= mul_a;
                y_reg      <= mul_y;
            end
            S_MUL2:
            begin
                prod_b_reg <= mul_b;
                neg_reg    <= y_reg[33];
                ymag_reg   <= y_abs[31:0];
            end
            S_DIV:
            begin
                plo_reg <= ymag_reg * RECIP_LO;
                phi_reg <= ymag_reg * RECIP_HI;
            end
            S_QUO:
            begin
                quo_reg <= quo_next;
            end
            S_DSAT:
            begin
                d_reg <= cur_reg.dvalid ? sat32(d_wide) : '0;
            end
            S_PROD:
            begin
                pp_reg <= $signed(cfg.gain_p) * $signed(cur_reg.sample);
                pi_reg <= $signed(cfg.gain_i) * integ_reg;
                pd_reg <= $signed(cfg.gain_d) * d_reg;
            end
            S_SUM1:
            begin
                acc_reg <= sum1;
            end
            default:
            begin
            end
        endcase
    end

    a_quo_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QUO && cur_reg.dvalid)
        |=> ((48'({ymag_reg, 8'd0}) - 48'(quo_reg) * 48'(HISTORY_DEPTH))
             < 48'(HISTORY_DEPTH)))
        else $error("window divide quotient is off");

    a_d_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DSAT && !cur_reg.dvalid) |=> (d_reg == '0))
        else $error("derivative used before the window is full");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM2 && out_valid_reg && !m_tready)
        |=> (state_reg == S_SUM2 && out_valid_reg && $stable(out_data_reg)))
        else $error("result overwritten while output stalled");

endmodule

// ===== rtl/pid_leaky_integral_window_derivative.sv =====
// ----------------------------------------------------------------------------
// pid_leaky_integral_window_derivative
// Fixed-point PID controller with a leaky integral and windowed derivative.
// ----------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata carry one Q8.8 error sample per timer tick.
//   m_tvalid/m_tready/m_tdata/m_tuser return one result per sample: the
//   saturated Q16.16 drive value and the derivative-valid flag.
//   The APB port sets gains, leak alpha, tick period and tick rate; write it
//   only while no sample is in flight.
// Timing:
//   The back-end sequencer finishes one sample before it takes the next: it
//   takes the request, runs the MUL1 and MUL2 multiply steps, the integral
//   update, two steps of the reciprocal multiply that divides by HISTORY_DEPTH,
//   and the saturate, product and sum steps; the last waits for a free output.
//   A two-entry request queue and the output register keep accepting samples
//   while a result waits; when the queue fills, s_tready drops until the back end pops.
// Reset:
//   rst_n clears the integral, fill count, queue and output valid and loads
//   the register defaults. The first HISTORY_DEPTH-1 results carry a zero
//   derivative and m_tuser low.
// ----------------------------------------------------------------------------
module pid_leaky_integral_window_derivative
    import pid_pkg::*;
#(
    parameter int HISTORY_DEPTH = PID_HISTORY_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] error_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [31:0] drive_value
    output logic                  m_tuser    // [0] derivative_valid
);

    pid_cfg_t  cfg;
    pid_item_t push_item;
    pid_item_t pop_item;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;

    pid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pid_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    pid_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    pid_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .q_empty          (q_empty),
        .pop              (pop),
        .q_item           (pop_item),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .drive_value      (m_tdata),
        .derivative_valid (m_tuser)
    );

endmodule
